FILE: hw/rtl/circular_deque_defines.svh
// Assertion macros shared by the circular deque RTL.
// Included by files that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define CDQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define CDQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/cdq_pkg.sv
// Shared types and constants for the circular deque.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package cdq_pkg;

  localparam int unsigned DEPTH    = 8;
  localparam int unsigned IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned STATUS_W = 2;

  // Stream payload widths, rounded up to whole bytes
  localparam int unsigned IN_BITS  = CMD_W + DATA_W;
  localparam int unsigned OUT_BITS = DATA_W + STATUS_W + 2;
  localparam int unsigned IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_REAR  = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    DSEL_ZERO    = 2'd0,
    DSEL_MEM     = 2'd1,
    DSEL_REFUSED = 2'd2
  } data_sel_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_HOLD = 1'b1
  } state_e;

  // Controller to datapath: one operation, applied when load is high
  typedef struct packed {
    logic      load;
    logic      wr_en;
    logic      wr_front;
    logic      init;
    logic      rd_en;
    logic      rd_front;
    logic      pop;
    logic      pop_last;
    status_e   status;
    data_sel_e dsel;
  } op_t;

  // Datapath to controller: occupancy as it stands now
  typedef struct packed {
    logic empty;
    logic full;
    logic single;
  } dp_stat_t;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    return (i == IDX_LAST) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_LAST : i - IDX_W'(1);
  endfunction

endpackage

FILE: hw/rtl/circular_deque.sv
// Circular double-ended queue of DEPTH 32-bit entries, stream in and out.
//
// Input channel (s_axis): each transfer carries a command (push front, push rear,
// pop front, pop rear, peek front, peek rear) and a value used only by pushes.
// Output channel (m_axis): exactly one result per input transfer, in order, with
// the data, a status code (done, refused full, refused empty) and the empty and
// full flags as they stand after the operation.
// Result: registered, and presented in the cycle after the input transfer.
// Throughput: one item per cycle while m_axis_tready_i is high; each item makes at
// most one memory access and lands in one output register, which sets that figure.
// Stall: while a result waits for m_axis_tready_i, s_axis_tready_o follows
// m_axis_tready_i, so a new item enters in the same cycle the held result leaves.
// Reset: the deque comes up empty with both indices at zero and no result held;
// the element memory is not cleared, only written entries are ever read.
// Depends on cdq_pkg, cdq_ctrl, cdq_datapath and circular_deque_defines.svh.
`timescale 1ns / 1ps
`include "circular_deque_defines.svh"

module circular_deque import cdq_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // command [2:0], push_value [34:3], zero fill above
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // data_out [31:0], status [33:32], empty_flag [34], full_flag [35], zero fill above
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  cmd_e                     command;
  logic signed [DATA_W-1:0] push_value;
  op_t                      op;
  dp_stat_t                 stat;
  logic signed [DATA_W-1:0] data_out;
  status_e                  status;
  logic                     empty_flag;
  logic                     full_flag;

  assign command    = cmd_e'(s_axis_tdata_i[CMD_W-1:0]);
  assign push_value = s_axis_tdata_i[CMD_W +: DATA_W];

  cdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .command_i   (command),
    .stat_i      (stat),
    .op_o        (op)
  );

  cdq_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op),
    .push_value_i (push_value),
    .stat_o       (stat),
    .data_out_o   (data_out),
    .status_o     (status),
    .empty_flag_o (empty_flag),
    .full_flag_o  (full_flag)
  );

  assign m_axis_tdata_o = {{OUT_PAD_W{1'b0}}, full_flag, empty_flag, status, data_out};

  `CDQ_ASSERT_IMP(a_flags_exclusive, stat.empty, !stat.full && stat.single,
                  "empty deque must not look full and must have head equal to tail")

  `CDQ_ASSERT_NXT(a_refused_empty, op.load && stat.empty && op.rd_en == 1'b0 &&
                  op.dsel == DSEL_REFUSED,
                  m_axis_tvalid_o && status == ST_EMPTY && data_out == '1 && empty_flag,
                  "refused pop or peek must report empty status and all-ones data")

  `CDQ_ASSERT_NXT(a_push_not_empty, op.load && op.wr_en,
                  m_axis_tvalid_o && status == ST_DONE && !empty_flag && !stat.empty,
                  "accepted push must leave the deque non-empty")

endmodule

FILE: hw/rtl/cdq_ctrl.sv
// Controller for the circular deque: output-slot state machine and command decode.
// Depends on cdq_pkg; drives the datapath through op_t and reads dp_stat_t.
`timescale 1ns / 1ps

module cdq_ctrl import cdq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  cmd_e     command_i,
  input  dp_stat_t stat_i,
  output op_t      op_o
);

  state_e state_q, state_d;
  logic   accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_HOLD;
      end
      S_HOLD: begin
        if (out_ready_i && !accept) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs and decode
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
      end
      S_HOLD: begin
        out_valid_o = 1'b1;
        // with out_ready_i high the held result leaves this cycle, so the slot is free again
        in_ready_o  = out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
    accept = in_valid_i && in_ready_o;

    op_o          = '0;
    op_o.load     = accept;
    op_o.status   = ST_DONE;
    op_o.dsel     = DSEL_ZERO;
    case (command_i)
      CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
        if (stat_i.full) begin
          op_o.status = ST_FULL;
        end else begin
          op_o.wr_en    = 1'b1;
          op_o.init     = stat_i.empty;
          op_o.wr_front = (command_i == CMD_PUSH_FRONT);
        end
      end
      CMD_POP_FRONT, CMD_POP_REAR, CMD_PEEK_FRONT, CMD_PEEK_REAR: begin
        if (stat_i.empty) begin
          op_o.status = ST_EMPTY;
          op_o.dsel   = DSEL_REFUSED;
        end else begin
          op_o.rd_en    = 1'b1;
          op_o.dsel     = DSEL_MEM;
          op_o.rd_front = (command_i == CMD_POP_FRONT) || (command_i == CMD_PEEK_FRONT);
          op_o.pop      = (command_i == CMD_POP_FRONT) || (command_i == CMD_POP_REAR);
          op_o.pop_last = op_o.pop && stat_i.single;
        end
      end
      default: begin
        op_o.status = ST_DONE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/cdq_datapath.sv
// Datapath for the circular deque: element memory, head/tail indices, result register.
// Depends on cdq_pkg; executes the op_t issued by cdq_ctrl.
`timescale 1ns / 1ps

module cdq_datapath import cdq_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  op_t                     op_i,
  input  logic signed [DATA_W-1:0] push_value_i,
  output dp_stat_t                stat_o,
  output logic signed [DATA_W-1:0] data_out_o,
  output status_e                 status_o,
  output logic                    empty_flag_o,
  output logic                    full_flag_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_q;

  logic [IDX_W-1:0] head_q, head_d;
  logic [IDX_W-1:0] tail_q, tail_d;
  logic             empty_q, empty_d;
  logic             full_d;
  logic [IDX_W-1:0] wr_addr, rd_addr;

  status_e   status_q;
  data_sel_e dsel_q;
  logic      empty_flag_q, full_flag_q;

  assign stat_o.empty  = empty_q;
  assign stat_o.full   = !empty_q && (head_q == idx_inc(tail_q));
  assign stat_o.single = (head_q == tail_q);

  // Index update for the operation on offer
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    empty_d = empty_q;
    wr_addr = '0;
    if (op_i.wr_en) begin
      if (op_i.init) begin
        head_d  = '0;
        tail_d  = '0;
        empty_d = 1'b0;
      end else if (op_i.wr_front) begin
        head_d  = idx_dec(head_q);
        wr_addr = head_d;
      end else begin
        tail_d  = idx_inc(tail_q);
        wr_addr = tail_d;
      end
    end else if (op_i.pop) begin
      if (op_i.pop_last) begin
        head_d  = '0;
        tail_d  = '0;
        empty_d = 1'b1;
      end else if (op_i.rd_front) begin
        head_d = idx_inc(head_q);
      end else begin
        tail_d = idx_dec(tail_q);
      end
    end
    full_d  = !empty_d && (head_d == idx_inc(tail_d));
    rd_addr = op_i.rd_front ? head_q : tail_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
    end else if (op_i.load) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
    end
  end

  // Element memory, at most one access per transfer, registered read
  always_ff @(posedge clk_i) begin
    if (op_i.load && op_i.wr_en) begin
      mem[wr_addr] <= push_value_i;
    end
    if (op_i.load && op_i.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Result register; holds while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (op_i.load) begin
      status_q     <= op_i.status;
      dsel_q       <= op_i.dsel;
      empty_flag_q <= empty_d;
      full_flag_q  <= full_d;
    end
  end

  always_comb begin
    case (dsel_q)
      DSEL_MEM:     data_out_o = rd_q;
      DSEL_REFUSED: data_out_o = '1;
      default:      data_out_o = '0;
    endcase
  end

  assign status_o     = status_q;
  assign empty_flag_o = empty_flag_q;
  assign full_flag_o  = full_flag_q;

endmodule

FILE: tb/sv/deque_checker.sv
// Scoreboard for the circular deque: predicts every result from the accepted commands.
// Watches both stream channels; depends on cdq_pkg for widths, command and status codes.
`timescale 1ns / 1ps

module deque_checker import cdq_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_tvalid_i,
  input  logic                   in_tready_i,
  // command [2:0], push_value [34:3], zero fill above
  input  logic [IN_TDATA_W-1:0]  in_tdata_i,
  input  logic                   out_tvalid_i,
  input  logic                   out_tready_i,
  // data_out [31:0], status [33:32], empty_flag [34], full_flag [35], zero fill above
  input  logic [OUT_TDATA_W-1:0] out_tdata_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  typedef struct packed {
    logic [DATA_W-1:0] data;
    status_e           status;
    logic              empty;
    logic              full;
  } deque_result_t;

  // Shadow copy of the deque contents and pointers
  logic [DATA_W-1:0] slots [DEPTH];
  int unsigned       front_pos;
  int unsigned       rear_pos;
  bit                vacant;
  deque_result_t     awaited_q [$];
  int                mismatches;

  function automatic int unsigned wrap_up(input int unsigned pos);
    return (pos + 1 == DEPTH) ? 0 : pos + 1;
  endfunction

  function automatic int unsigned wrap_down(input int unsigned pos);
    return (pos == 0) ? DEPTH - 1 : pos - 1;
  endfunction

  function automatic bit store_full();
    return !vacant && front_pos == wrap_up(rear_pos);
  endfunction

  // Apply one command to the shadow deque and return the result it must produce
  function automatic deque_result_t apply_command(input logic [CMD_W-1:0]  cmd,
                                                  input logic [DATA_W-1:0] value);
    deque_result_t res;
    int unsigned   pos;
    bit            front_side;
    res.data   = '0;
    res.status = ST_DONE;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
        if (store_full()) begin
          res.status = ST_FULL;
        end else begin
          if (vacant) begin
            // first element always lands in slot zero
            vacant    = 1'b0;
            front_pos = 0;
            rear_pos  = 0;
            pos       = 0;
          end else if (cmd == CMD_PUSH_FRONT) begin
            front_pos = wrap_down(front_pos);
            pos       = front_pos;
          end else begin
            rear_pos = wrap_up(rear_pos);
            pos      = rear_pos;
          end
          slots[pos] = value;
        end
      end
      CMD_POP_FRONT, CMD_POP_REAR, CMD_PEEK_FRONT, CMD_PEEK_REAR: begin
        if (vacant) begin
          res.data   = '1;
          res.status = ST_EMPTY;
        end else begin
          front_side = (cmd == CMD_POP_FRONT || cmd == CMD_PEEK_FRONT);
          res.data   = slots[front_side ? front_pos : rear_pos];
          if (cmd == CMD_POP_FRONT || cmd == CMD_POP_REAR) begin
            if (front_pos == rear_pos) begin
              vacant    = 1'b1;
              front_pos = 0;
              rear_pos  = 0;
            end else if (front_side) begin
              front_pos = wrap_up(front_pos);
            end else begin
              rear_pos = wrap_down(rear_pos);
            end
          end
        end
      end
      default: ;  // unused codes leave the deque alone
    endcase
    res.empty = vacant;
    res.full  = store_full();
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    deque_result_t want;
    deque_result_t got;
    if (!rst_ni) begin
      foreach (slots[i]) slots[i] = '0;
      front_pos  = 0;
      rear_pos   = 0;
      vacant     = 1'b1;
      mismatches = 0;
      awaited_q.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // Predict first, so a same-edge result still meets the oldest entry
      if (in_tvalid_i && in_tready_i) begin
        awaited_q.push_back(apply_command(in_tdata_i[CMD_W-1:0], in_tdata_i[CMD_W +: DATA_W]));
      end
      if (out_tvalid_i && out_tready_i) begin
        got.data   = out_tdata_i[DATA_W-1:0];
        got.status = status_e'(out_tdata_i[DATA_W +: STATUS_W]);
        got.empty  = out_tdata_i[DATA_W + STATUS_W];
        got.full   = out_tdata_i[DATA_W + STATUS_W + 1];
        if (awaited_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result data=%h status=%0d empty=%b full=%b",
                     $realtime, got.data, got.status, got.empty, got.full);
        end else begin
          want = awaited_q.pop_front();
          if (got.data !== want.data || got.status !== want.status ||
              got.empty !== want.empty || got.full !== want.full) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch expected data=%h status=%0d empty=%b full=%b, %s%h %s%0d %s%b %s%b",
                       $realtime, want.data, want.status, want.empty, want.full,
                       "got data=", got.data, "status=", got.status,
                       "empty=", got.empty, "full=", got.full);
          end
        end
      end
      pending_o    <= awaited_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

FILE: tb/sv/testbench.sv
// Top of the circular deque testbench: clock, reset, command stimulus and the verdict.
// Instantiates circular_deque and deque_checker; depends on cdq_pkg.
`timescale 1ns / 1ps

module testbench;
  import cdq_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_ITEMS = 1900;

  logic                   clk_i   = 1'b0;
  logic                   rst_ni  = 1'b0;
  logic                   s_valid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_data  = '0;
  logic                   s_ready;
  logic                   m_valid;
  logic                   m_ready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_data;
  bit                     calm    = 1'b0;
  int unsigned            cycles  = 0;
  int                     fail_count;
  int                     pending;

  always #10 clk_i = ~clk_i;

  circular_deque DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  deque_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_tvalid_i  (s_valid),
    .in_tready_i  (s_ready),
    .in_tdata_i   (s_data),
    .out_tvalid_i (m_valid),
    .out_tready_i (m_ready),
    .out_tdata_i  (m_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Receiver back-pressure, off during the calm stretch
  always @(posedge clk_i) begin
    m_ready <= calm || ($urandom_range(99) >= 32);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offer one command and hold it until the transfer completes
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value);
    while (!calm && $urandom_range(99) < 32) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= IN_TDATA_W'({value, cmd});
    do @(posedge clk_i); while (!s_ready);
  endtask

  initial begin : stimulus
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] value;
    int unsigned       roll;
    int unsigned       mode;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Refusals on an empty deque, unused code, push into empty, pop of the last element
    send_command(CMD_POP_FRONT, 32'h1234_5678);
    send_command(CMD_POP_REAR, '0);
    send_command(CMD_PEEK_FRONT, '0);
    send_command(CMD_PEEK_REAR, '1);
    send_command(CMD_W'(CMD_PEEK_REAR + 1), 32'hFFFF_FFFF);
    send_command(CMD_PUSH_REAR, 32'h7FFF_FFFF);
    send_command(CMD_PEEK_FRONT, '0);
    send_command(CMD_POP_REAR, '0);
    send_command(CMD_PUSH_FRONT, 32'h8000_0000);
    send_command(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
    // Fill to capacity, then push against a full deque
    for (int i = 1; i <= DEPTH - 2; i++) begin
      send_command(CMD_PUSH_REAR, 32'h0101_0101 * i);
    end
    send_command(CMD_PUSH_FRONT, 32'hDEAD_BEEF);
    send_command(CMD_PUSH_REAR, 32'h0000_0000);
    send_command(CMD_W'(CMD_PEEK_REAR + 2), '0);
    send_command(CMD_PEEK_REAR, '0);
    send_command(CMD_POP_FRONT, '0);
    send_command(CMD_POP_REAR, '0);

    // Drain every outstanding result before going random
    s_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm <= (i >= 700 && i < 1000);
      // Alternate fill-heavy, drain-heavy and balanced phases to hit full, empty and wrap
      mode = (i / 30) % 3;
      roll = $urandom_range(99);
      if (roll < 3) begin
        cmd = CMD_W'(CMD_PEEK_REAR + 1 + $urandom_range(1));
      end else if ((mode == 0 && roll < 70) || (mode == 1 && roll < 25) ||
                   (mode == 2 && roll < 50)) begin
        cmd = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
      end else begin
        cmd = CMD_W'(CMD_POP_FRONT + $urandom_range(3));
      end
      case ($urandom_range(19))
        0:       value = 32'h7FFF_FFFF;
        1:       value = 32'h8000_0000;
        2:       value = '1;
        3:       value = '0;
        default: value = $urandom;
      endcase
      send_command(cmd, value);
    end
    s_valid <= 1'b0;
    calm    <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    // Leave room for any stray result
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
